/* rtl/keyed_occurrence_count_table_macros.svh */
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef KEYED_OCCURRENCE_COUNT_TABLE_MACROS_SVH
`define KEYED_OCCURRENCE_COUNT_TABLE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define KOCNT_ASSERT_SAME(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define KOCNT_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/kocnt_pkg.sv */
`timescale 1ns / 1ps

package kocnt_pkg;

	localparam int unsigned ENTRIES    = 64;
	localparam int unsigned COUNT_BITS = 16;
	localparam int unsigned KEY_BITS   = 32;
	localparam int unsigned OUT_BITS   = 16;
	localparam int unsigned FILL_W     = $clog2(ENTRIES + 1);
	localparam int unsigned WIDE_W     = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
	localparam int unsigned OUT_MAX    = (1 << OUT_BITS) - 1;

	typedef enum logic [1:0] {
		REQ_COUNT = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_type_t;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]                 req_type;
		logic signed [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] count;
		logic                status;
	} res_t;

	function automatic logic [OUT_BITS-1:0] report_count(input logic [COUNT_BITS-1:0] c);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(c);
		if (w > WIDE_W'(OUT_MAX))
			return '1;
		return OUT_BITS'(w);
	endfunction

endpackage

/* rtl/kocnt_table.sv */
`timescale 1ns / 1ps
`include "keyed_occurrence_count_table_macros.svh"

module kocnt_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  kocnt_pkg::req_t   req,
	output kocnt_pkg::res_t   res
);

	localparam int unsigned ENTRIES = kocnt_pkg::ENTRIES;
	localparam int unsigned CB      = kocnt_pkg::COUNT_BITS;
	localparam int unsigned FW      = kocnt_pkg::FILL_W;
	localparam int unsigned KB      = kocnt_pkg::KEY_BITS;
	localparam int unsigned OB      = kocnt_pkg::OUT_BITS;

	logic signed [KB-1:0] key_q [ENTRIES];
	logic [CB-1:0]        cnt_q [ENTRIES];
	logic [FW-1:0]        fill_q;

	logic [ENTRIES-1:0]   hit;
	logic [CB-1:0]        match_cnt;
	logic [CB-1:0]        inc_cnt;
	logic                 any_hit;
	logic                 full;
	logic                 do_inc;
	logic                 do_alloc;
	logic                 do_clear;

	always_comb begin
		hit       = '0;
		match_cnt = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit[i] = (FW'(i) < fill_q) && (key_q[i] == req.key);
			if (hit[i])
				match_cnt = match_cnt | cnt_q[i];
		end
		any_hit  = |hit;
		full     = (fill_q == FW'(ENTRIES));
		inc_cnt  = (match_cnt == '1) ? match_cnt : match_cnt + CB'(1);
		do_inc   = 1'b0;
		do_alloc = 1'b0;
		do_clear = 1'b0;
		res      = '0;
		res.status = kocnt_pkg::STATUS_DONE;
		case (req.req_type)
			kocnt_pkg::REQ_COUNT: begin
				if (any_hit) begin
					do_inc    = 1'b1;
					res.count = kocnt_pkg::report_count(inc_cnt);
				end else if (!full) begin
					do_alloc  = 1'b1;
					res.count = OB'(1);
				end else begin
					res.status = kocnt_pkg::STATUS_FULL;
				end
			end
			kocnt_pkg::REQ_QUERY: begin
				if (any_hit)
					res.count = kocnt_pkg::report_count(match_cnt);
			end
			kocnt_pkg::REQ_CLEAR: begin
				do_clear = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (fire && do_inc && hit[i])
				cnt_q[i] <= inc_cnt;
			if (fire && do_alloc && (FW'(i) == fill_q)) begin
				key_q[i] <= req.key;
				cnt_q[i] <= CB'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (fire) begin
			if (do_clear)
				fill_q <= '0;
			else if (do_alloc)
				fill_q <= fill_q + FW'(1);
		end
	end

	`KOCNT_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= FW'(ENTRIES), "fill beyond table size")
	`KOCNT_ASSERT_NEXT(a_clear_empties, fire && do_clear, fill_q == '0, "clear left entries")
	`KOCNT_ASSERT_SAME(a_full_only_when_full, fire && res.status, full && !any_hit,
		"full status with room or match")
	`KOCNT_ASSERT_SAME(a_count_nonzero, fire && req.req_type == kocnt_pkg::REQ_COUNT && !res.status,
		res.count != '0, "counted key reports zero")
	`KOCNT_ASSERT_SAME(a_unique_match, 1'b1, $onehot0(hit), "key stored twice")

endmodule

/* rtl/keyed_occurrence_count_table.sv */
`timescale 1ns / 1ps
// Keyed occurrence counter: up to 64 distinct 32-bit keys, 16-bit counts.
// Input stream s_*: s_tuser[1:0] selects the request (0 count, 1 query,
// 2 clear, 3 no-op), s_tdata carries the key. Every word yields one result.
// Output stream m_*: m_tdata is the count after the request, m_tuser is the
// full flag, set when a new key is dropped because all entries are taken.
// A count of an unknown key takes the next free entry with count 1; counts
// saturate at their maximum. A query never allocates; a clear empties the table.
// A word accepted on s_* goes to the input register, and its result to the
// output register on m_*. Throughput: one word per cycle unless m_tready stalls,
// set by the combinational parallel key compare and update between the registers.
// Reset empties the table and drops any word in flight; no clearing pass.
// When m_tready is low the result holds in the output register; one more
// word waits in the input register, after which s_tready falls.

module keyed_occurrence_count_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // key[31:0]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // count[15:0]
	output logic        m_tuser    // status[0]
);

	logic                valid_s1;
	kocnt_pkg::req_t     req_s1;
	kocnt_pkg::res_t     res;
	logic                out_valid_q;
	kocnt_pkg::res_t     res_q;
	logic                out_free;
	logic                fire;

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.req_type <= s_tuser;
			req_s1.key      <= s_tdata;
		end
	end

	kocnt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q.count;
	assign m_tuser  = res_q.status;

endmodule
